>>> sv/jsls_pkg.sv
// Shared types, constants and helpers for the Jacobi/SOR linear solver.
package jsls_pkg;

   localparam int MaxN = 16;
   localparam int IdxW = $clog2(MaxN);
   localparam int CntW = $clog2(MaxN + 1);

   localparam logic [1:0] OpLoadA = 2'd0;
   localparam logic [1:0] OpLoadF = 2'd1;
   localparam logic [1:0] OpStart = 2'd2;

   localparam logic [2:0] RegMode  = 3'd0;
   localparam logic [2:0] RegOmega = 3'd1;
   localparam logic [2:0] RegTol   = 3'd2;
   localparam logic [2:0] RegMaxIt = 3'd3;
   localparam logic [2:0] RegSize  = 3'd4;

   localparam logic signed [63:0] Max32 = 64'sd2147483647;
   localparam logic signed [63:0] Min32 = -64'sd2147483648;

   // Datapath commands issued by the controller.
   typedef struct packed {
      logic          init_ld;   // copy f into x and p at init_idx
      logic [IdxW-1:0] init_idx;
      logic          acc_clr;   // start a new row
      logic          mac_en;    // accumulate one product unless col equals row
      logic [IdxW-1:0] row;
      logic [IdxW-1:0] col;
      logic          div_go;    // start the row divide
      logic          copy_en;   // copy x to p at init_idx
      logic          out_rd;    // read x at init_idx for output
   } jsls_cmd_type;

   typedef struct packed {
      logic          div_done;
      logic          row_small; // |x_new - p| < tol for the row just written
   } jsls_sts_type;

   function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = v;
      if (v > Max32) r = Max32;
      if (v < Min32) r = Min32;
      return r;
   endfunction

endpackage

>>> sv/jsls_divider.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
module jsls_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic signed [63:0] dividend,
   input  logic signed [31:0] divisor,
   output logic               done,
   output logic signed [63:0] quotient
);
   import jsls_pkg::*;

   logic [63:0] num_ff, num_in;
   logic [63:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;

   // Advance one bit of long division per cycle.
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[63]} - {33'd0, den_ff};
      if (go) begin
         num_in  = dividend[63] ? 64'(-dividend) : 64'(dividend);
         den_in  = divisor[31] ? 32'(-divisor) : 32'(divisor);
         neg_in  = dividend[63] ^ divisor[31];
         rem_in  = '0;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            num_in = {num_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], num_ff[63]};
            num_in = {num_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(num_ff) : $signed(num_ff);
endmodule

>>> sv/jsls_datapath.sv
// Solver datapath: stores, multiply-accumulate, divide and blend.
module jsls_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     ld_a,
   input  logic                     ld_f,
   input  logic [jsls_pkg::IdxW-1:0] ld_row,
   input  logic [jsls_pkg::IdxW-1:0] ld_col,
   input  logic signed [31:0]       ld_value,
   input  logic                     sor,
   input  logic [17:0]              omega,
   input  logic [16:0]              tolerance,
   input  jsls_pkg::jsls_cmd_type   cmd,
   output jsls_pkg::jsls_sts_type   sts,
   output logic signed [31:0]       out_value
);
   import jsls_pkg::*;

   logic signed [31:0] a_mem [MaxN*MaxN];
   logic signed [31:0] f_mem [MaxN];
   logic signed [31:0] x_mem [MaxN];
   logic signed [31:0] p_mem [MaxN];

   logic signed [31:0] a_rd_ff, xs_rd_ff, f_rd_ff, p_rd_ff, d_ff;
   logic               mac_ff, mac2_ff;
   logic signed [63:0] prod_ff;
   logic signed [63:0] acc_ff;
   logic signed [63:0] blend_ff;
   logic signed [63:0] num_s;
   logic signed [63:0] qv;
   logic signed [63:0] newx;
   logic signed [63:0] diff;
   logic signed [31:0] newx_ff;
   logic               wpend_ff;
   logic               small_ff;
   logic               dz;
   logic               div_done;
   logic signed [63:0] quot;
   logic signed [31:0] x_src;
   logic [2*IdxW-1:0]  a_addr;
   logic signed [18:0] wgt;
   logic signed [18:0] bw;
   logic signed [63:0] sacc;

   assign a_addr = cmd.mac_en ? {cmd.row, cmd.col} : {cmd.row, cmd.row};
   assign x_src  = sor ? x_mem[cmd.col] : p_mem[cmd.col];
   assign wgt    = sor ? $signed({1'b0, omega}) : 19'sd65536;
   assign bw     = 19'sd65536 - $signed({1'b0, omega});

   // Write stores and read operands.
   always_ff @(posedge clock) begin
      if (ld_a) a_mem[{ld_row, ld_col}] <= ld_value;
      if (ld_f) f_mem[ld_row] <= ld_value;
      if (cmd.init_ld) begin
         x_mem[cmd.init_idx] <= f_mem[cmd.init_idx];
         p_mem[cmd.init_idx] <= f_mem[cmd.init_idx];
      end
      if (cmd.copy_en) p_mem[cmd.init_idx] <= x_mem[cmd.init_idx];
      if (wpend_ff) x_mem[cmd.row] <= newx_ff;
      a_rd_ff  <= a_mem[a_addr];
      xs_rd_ff <= x_src;
      f_rd_ff  <= f_mem[cmd.row];
      p_rd_ff  <= p_mem[cmd.row];
      if (cmd.out_rd) out_value <= x_mem[cmd.init_idx];
   end

   // Multiply, then accumulate the floored product.
   always_ff @(posedge clock) begin
      prod_ff <= 64'(a_rd_ff) * 64'(xs_rd_ff);
      if (cmd.acc_clr) acc_ff <= 64'(f_mem[cmd.row]);
      else if (mac2_ff) acc_ff <= acc_ff - (prod_ff >>> 16);
      if (reset) begin
         mac_ff  <= 1'b0;
         mac2_ff <= 1'b0;
      end else begin
         mac_ff  <= cmd.mac_en && (cmd.col != cmd.row);
         mac2_ff <= mac_ff;
      end
   end

   // Scale the saturated sum and form the blend term at divide start.
   assign sacc  = sat32(acc_ff);
   assign num_s = sacc * 64'(wgt);
   always_ff @(posedge clock) begin
      if (cmd.div_go) begin
         d_ff     <= a_rd_ff;
         blend_ff <= sor ? ((64'(bw) * 64'(p_rd_ff)) >>> 16) : 64'sd0;
      end
   end

   jsls_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.div_go),
      .dividend (num_s),
      .divisor  (a_rd_ff),
      .done     (div_done),
      .quotient (quot)
   );

   // Pick the quotient, add the blend and saturate.
   logic sneg_ff;
   always_ff @(posedge clock) begin
      if (cmd.div_go) sneg_ff <= sacc[63];
   end
   assign dz   = (d_ff == 32'sd0);
   assign qv   = dz ? (sneg_ff ? Min32 : Max32) : quot;
   assign newx = sat32(qv + blend_ff);
   assign diff = newx - 64'(p_rd_ff);

   always_ff @(posedge clock) begin
      newx_ff <= newx[31:0];
      if (reset) begin
         wpend_ff <= 1'b0;
         small_ff <= 1'b0;
      end else begin
         wpend_ff <= div_done;
         if (div_done)
            small_ff <= ((diff[63] ? -diff : diff) < 64'(tolerance));
      end
   end

   assign sts.div_done  = wpend_ff;
   assign sts.row_small = small_ff;
endmodule

>>> sv/jsls_ctrl.sv
// Solver sequencer: init, sweeps, convergence test and result output.
module jsls_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start_go,
   input  logic [4:0]               size,
   input  logic [9:0]               max_it,
   output jsls_pkg::jsls_cmd_type   cmd,
   input  jsls_pkg::jsls_sts_type   sts,
   output logic                     busy,
   output logic                     out_strobe,
   output logic [jsls_pkg::IdxW-1:0] out_index,
   output logic                     out_conv,
   output logic [9:0]               out_iters,
   output logic                     out_last
);
   import jsls_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_ROW, S_MAC, S_DRAIN, S_DIAG, S_DIV, S_WAIT, S_CHK,
      S_COPY, S_OUTRD, S_OUT
   } state_type;

   state_type         state_ff;
   logic [CntW-1:0]   n_ff;
   logic [IdxW-1:0]   i_ff;
   logic [IdxW-1:0]   j_ff;
   logic [1:0]        dr_ff;
   logic [9:0]        k_ff;
   logic [9:0]        lim_ff;
   logic              big_ff;
   logic              conv_ff;
   logic              stb_ff;
   logic [IdxW-1:0]   nm1;

   assign nm1 = IdxW'(n_ff - CntW'(1));

   // Drive datapath commands from state.
   always_comb begin
      cmd = '0;
      cmd.init_idx = i_ff;
      cmd.row = i_ff;
      cmd.col = j_ff;
      case (state_ff)
         S_INIT:  cmd.init_ld = 1'b1;
         S_ROW:   cmd.acc_clr = 1'b1;
         S_MAC:   cmd.mac_en = 1'b1;
         S_DIV:   cmd.div_go = 1'b1;
         S_COPY:  cmd.copy_en = 1'b1;
         S_OUTRD: cmd.out_rd = 1'b1;
         default: ;
      endcase
   end

   // Hold state, counters and the output strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stb_ff   <= 1'b0;
      end else begin
         stb_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (start_go && size != 5'd0) begin
               n_ff   <= (size > 5'(MaxN)) ? CntW'(MaxN) : CntW'(size);
               lim_ff <= max_it;
               i_ff   <= '0;
               k_ff   <= '0;
               conv_ff <= 1'b0;
               state_ff <= S_INIT;
            end
            S_INIT: begin
               i_ff <= i_ff + IdxW'(1);
               if (i_ff == nm1) begin
                  i_ff <= '0;
                  big_ff <= 1'b0;
                  state_ff <= (lim_ff == 10'd0) ? S_OUTRD : S_ROW;
               end
            end
            S_ROW: begin
               j_ff <= '0;
               state_ff <= S_MAC;
            end
            S_MAC: begin
               j_ff <= j_ff + IdxW'(1);
               if (j_ff == nm1) begin
                  dr_ff <= 2'd0;
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               dr_ff <= dr_ff + 2'd1;
               if (dr_ff == 2'd2) state_ff <= S_DIAG;
            end
            S_DIAG: state_ff <= S_DIV;
            S_DIV:  state_ff <= S_WAIT;
            S_WAIT: if (sts.div_done) state_ff <= S_CHK;
            S_CHK: begin
               if (!sts.row_small) big_ff <= 1'b1;
               if (i_ff == nm1) begin
                  i_ff <= '0;
                  if (sts.row_small && !big_ff) begin
                     conv_ff <= 1'b1;
                     state_ff <= S_OUTRD;
                  end else state_ff <= S_COPY;
               end else begin
                  i_ff <= i_ff + IdxW'(1);
                  state_ff <= S_ROW;
               end
            end
            S_COPY: begin
               i_ff <= i_ff + IdxW'(1);
               if (i_ff == nm1) begin
                  i_ff <= '0;
                  big_ff <= 1'b0;
                  k_ff <= k_ff + 10'd1;
                  state_ff <= (k_ff + 10'd1 == lim_ff) ? S_OUTRD : S_ROW;
               end
            end
            S_OUTRD: state_ff <= S_OUT;
            S_OUT: begin
               stb_ff <= 1'b1;
               out_index <= i_ff;
               out_last <= (i_ff == nm1);
               out_conv <= conv_ff;
               out_iters <= k_ff;
               i_ff <= i_ff + IdxW'(1);
               state_ff <= (i_ff == nm1) ? S_IDLE : S_OUTRD;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE) || stb_ff;
   assign out_strobe = stb_ff;
endmodule

>>> sv/jacobi_sor_linear_solver.sv
// Top level of the Jacobi/SOR iterative linear solver.
// Load words (op 0 matrix entry, op 1 right-hand side) are taken only while
// busy is low and can then follow back to back. A start word holds busy high
// for the whole solve: setup, then per sweep the row multiply-accumulate
// (one term a cycle) and a bit-serial divider for each row, then a copy of
// the iterate unless the sweep converged; then n results, each valid for a
// single cycle on rsp_valid. The receiver cannot stall, so it must take every
// result as it appears.
module jacobi_sor_linear_solver (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_op,
   input  logic [3:0]                 req_row,
   input  logic [3:0]                 req_col,
   input  logic signed [31:0]         req_value,
   output logic                       rsp_valid,
   output logic [3:0]                 rsp_index,
   output logic signed [31:0]         rsp_solution,
   output logic                       rsp_converged,
   output logic [9:0]                 rsp_iterations,
   output logic                       rsp_last,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [2:0]                 csr_index,
   input  logic [31:0]                csr_data
);
   import jsls_pkg::*;

   logic        mode_ff;
   logic [17:0] omega_ff;
   logic [16:0] tol_ff;
   logic [9:0]  maxit_ff;
   logic [4:0]  size_ff;
   logic        acc;
   jsls_cmd_type cmd;
   jsls_sts_type sts;

   assign acc = start && !busy;
   assign csr_ready = 1'b1;

   // Hold the configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         omega_ff <= 18'd65536;
         tol_ff   <= 17'd7;
         maxit_ff <= 10'd1000;
         size_ff  <= 5'd12;
      end else if (csr_valid) begin
         case (csr_index)
            RegMode:  mode_ff  <= csr_data[0];
            RegOmega: omega_ff <= csr_data[17:0];
            RegTol:   tol_ff   <= csr_data[16:0];
            RegMaxIt: maxit_ff <= csr_data[9:0];
            RegSize:  size_ff  <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   jsls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start_go   (acc && req_op == OpStart),
      .size       (size_ff),
      .max_it     (maxit_ff),
      .cmd        (cmd),
      .sts        (sts),
      .busy       (busy),
      .out_strobe (rsp_valid),
      .out_index  (rsp_index),
      .out_conv   (rsp_converged),
      .out_iters  (rsp_iterations),
      .out_last   (rsp_last)
   );

   jsls_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .ld_a      (acc && req_op == OpLoadA),
      .ld_f      (acc && req_op == OpLoadF),
      .ld_row    (req_row),
      .ld_col    (req_col),
      .ld_value  (req_value),
      .sor       (mode_ff),
      .omega     (omega_ff),
      .tolerance (tol_ff),
      .cmd       (cmd),
      .sts       (sts),
      .out_value (rsp_solution)
   );
endmodule
